// ===== rtl/fsv_pkg.sv =====
// Shared types and constants for the FASTA stream validator.
package fsv_pkg;

   localparam logic [7:0] CHAR_GT      = 8'h3E;   // '>'
   localparam logic [7:0] CHAR_NL      = 8'h0A;   // '\n'
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_G       = 8'h47;
   localparam logic [7:0] CHAR_T       = 8'h54;
   localparam logic [7:0] CHAR_N       = 8'h4E;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [2:0] {
      KIND_DROP     = 3'd0,
      KIND_NAMEBYTE = 3'd1,
      KIND_NAMEDONE = 3'd2,
      KIND_BASE     = 3'd3,
      KIND_RECEND   = 3'd4,
      KIND_OK       = 3'd5,
      KIND_ERROR    = 3'd6
   } kind_type;

   // byte classification handed from the classifier to the parser
   typedef struct packed {
      logic       is_marker;   // '>'
      logic       is_newline;
      logic       is_base;     // ACGTN either case
      logic [7:0] base_upper;  // uppercase base, zero if not a base
   } byte_class_type;

endpackage

// ===== rtl/fsv_classify.sv =====
// Byte classifier: header marker, newline, and uppercase folding of bases.
module fsv_classify (
   input  logic [7:0]             text_byte,
   output fsv_pkg::byte_class_type byte_class
);

   logic [7:0] folded;

   always_comb begin
      folded = text_byte;
      if (text_byte >= fsv_pkg::CHAR_LOWER_A && text_byte <= fsv_pkg::CHAR_LOWER_Z) begin
         folded = text_byte - fsv_pkg::CASE_OFFSET;
      end

      byte_class.is_marker  = (text_byte == fsv_pkg::CHAR_GT);
      byte_class.is_newline = (text_byte == fsv_pkg::CHAR_NL);
      byte_class.is_base    = (folded == fsv_pkg::CHAR_A) || (folded == fsv_pkg::CHAR_C) ||
                              (folded == fsv_pkg::CHAR_G) || (folded == fsv_pkg::CHAR_T) ||
                              (folded == fsv_pkg::CHAR_N);
      byte_class.base_upper = byte_class.is_base ? folded : 8'd0;
   end

endmodule

// ===== rtl/fasta_stream_validator.sv =====
// Top level: FASTA stream validator with input register, parser and result register.
//
// Accepts one FASTA text byte per request on the req_ side (or an end-of-stream
// request with req_tuser set) and returns exactly one result per request on the
// rsp_ side, in order. Throughput is one request per clock while rsp_tready
// holds; a request is taken into the input register, and the parse step then
// loads the result register, where rsp_tvalid rises.
// The parse step is a small state
// machine (first marker, header name, sequence, finished, error) fed by a
// byte classifier; its state advances when a request moves from the input
// register into the result register, so consecutive bytes go back to back.
// The stream must open with '>', each header name must be non-empty, sequence
// bytes ACGTN in either case come out uppercase, sequence newlines are dropped, '>' in
// sequence closes the record, and a blank line or any other byte is a sticky
// error. rsp_tuser carries the result kind: 0 dropped, 1 name byte, 2 name
// done, 3 base, 4 record end, 5 stream ok, 6 error.
module fasta_stream_validator (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tuser,   // [0] stream_end
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] result_value
   output logic [2:0] rsp_tuser    // [2:0] result_kind
);

   typedef enum logic [2:0] {
      MODE_FIRST = 3'd0,
      MODE_NAME  = 3'd1,
      MODE_SEQ   = 3'd2,
      MODE_DONE  = 3'd3,
      MODE_ERR   = 3'd4
   } mode_type;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;
   logic       in_end_ff,   in_end_in;

   // parser state
   mode_type   mode_ff,      mode_in;
   logic       prev_nl_ff,   prev_nl_in;
   logic       name_seen_ff, name_seen_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   fsv_pkg::kind_type out_kind_ff, out_kind_in;
   logic [7:0]       out_value_ff, out_value_in;

   fsv_pkg::byte_class_type byte_class;
   fsv_pkg::kind_type       kind;
   logic [7:0]              value;

   logic out_free;   // result register can take a new result this cycle
   logic advance;    // request moves from input register to result register

   fsv_classify u_classify (
      .text_byte  (in_byte_ff),
      .byte_class (byte_class)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // parse step for the request held in the input register
   always_comb begin
      mode_in      = mode_ff;
      prev_nl_in   = prev_nl_ff;
      name_seen_in = name_seen_ff;
      kind         = fsv_pkg::KIND_DROP;
      value        = 8'd0;

      unique case (mode_ff)
         MODE_ERR: begin
            kind = fsv_pkg::KIND_ERROR;
         end
         MODE_DONE: begin
            kind = in_end_ff ? fsv_pkg::KIND_OK : fsv_pkg::KIND_DROP;
         end
         MODE_FIRST: begin
            if (!in_end_ff && byte_class.is_marker) begin
               mode_in      = MODE_NAME;
               name_seen_in = 1'b0;
            end else begin
               kind    = fsv_pkg::KIND_ERROR;
               mode_in = MODE_ERR;
            end
         end
         MODE_NAME: begin
            if (in_end_ff) begin
               if (name_seen_ff) begin
                  kind    = fsv_pkg::KIND_OK;
                  mode_in = MODE_DONE;
               end else begin
                  kind    = fsv_pkg::KIND_ERROR;
                  mode_in = MODE_ERR;
               end
            end else if (byte_class.is_newline) begin
               if (name_seen_ff) begin
                  kind       = fsv_pkg::KIND_NAMEDONE;
                  mode_in    = MODE_SEQ;
                  prev_nl_in = 1'b1;
               end else begin
                  kind    = fsv_pkg::KIND_ERROR;
                  mode_in = MODE_ERR;
               end
            end else begin
               kind         = fsv_pkg::KIND_NAMEBYTE;
               value        = in_byte_ff;
               name_seen_in = 1'b1;
            end
         end
         MODE_SEQ: begin
            if (in_end_ff) begin
               kind    = fsv_pkg::KIND_OK;
               mode_in = MODE_DONE;
            end else if (byte_class.is_newline) begin
               if (prev_nl_ff) begin
                  // blank line
                  kind    = fsv_pkg::KIND_ERROR;
                  mode_in = MODE_ERR;
               end else begin
                  prev_nl_in = 1'b1;
               end
            end else if (byte_class.is_marker) begin
               kind         = fsv_pkg::KIND_RECEND;
               mode_in      = MODE_NAME;
               name_seen_in = 1'b0;
               prev_nl_in   = 1'b0;
            end else if (byte_class.is_base) begin
               kind       = fsv_pkg::KIND_BASE;
               value      = byte_class.base_upper;
               prev_nl_in = 1'b0;
            end else begin
               kind    = fsv_pkg::KIND_ERROR;
               mode_in = MODE_ERR;
            end
         end
         default: begin
            kind    = fsv_pkg::KIND_ERROR;
            mode_in = MODE_ERR;
         end
      endcase
   end

   // register next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_end_in    = in_end_ff;
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_kind_in  = kind;
         out_value_in = value;
         in_valid_in  = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_end_in   = req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_FIRST;
         prev_nl_ff   <= 1'b0;
         name_seen_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff      <= mode_in;
            prev_nl_ff   <= prev_nl_in;
            name_seen_ff <= name_seen_in;
         end
      end
      in_byte_ff   <= in_byte_in;
      in_end_ff    <= in_end_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_kind_ff;

endmodule
